>>> rtl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg: shared types and constants for the link connection supervisor
// Holds the state, command, action and register index codes, the reset
// values of the configuration registers and the bundles passed between
// the modules.
// ----------------------------------------------------------------------------
package lcs_pkg;

  // Link state, as reported on the result channel.
  typedef enum logic [2:0] {
    ST_DISC       = 3'd0,
    ST_CONNECTING = 3'd1,
    ST_CONNECTED  = 3'd2,
    ST_FAILED     = 3'd3,
    ST_AP         = 3'd4
  } state_e;

  // Commands carried by a request.
  typedef enum logic [2:0] {
    CMD_POLL       = 3'd0,
    CMD_CONNECT    = 3'd1,
    CMD_DISCONNECT = 3'd2,
    CMD_START_AP   = 3'd3,
    CMD_STOP_AP    = 3'd4
  } cmd_e;

  // Radio status codes.
  typedef enum logic [1:0] {
    LS_CONNECTED = 2'd0,
    LS_FAILED    = 2'd1,
    LS_ABSENT    = 2'd2,
    LS_OTHER     = 2'd3
  } link_status_e;

  // Radio action codes.
  typedef enum logic [2:0] {
    ACT_NONE          = 3'd0,
    ACT_JOIN          = 3'd1,
    ACT_LEAVE_AP_JOIN = 3'd2,
    ACT_START_AP      = 3'd3,
    ACT_LEAVE_AP      = 3'd4,
    ACT_ABORT_KEEP_AP = 3'd5,
    ACT_DROP          = 3'd6
  } action_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CONNECT_TIMEOUT = 3'd0,
    REG_DROP_TOLERANCE  = 3'd1,
    REG_BACKOFF_BASE    = 3'd2,
    REG_RETRY_LIMIT     = 3'd3,
    REG_REJOIN_INTERVAL = 3'd4,
    REG_REJOIN_TIMEOUT  = 3'd5
  } reg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Reset values of the configuration registers.
  localparam logic [31:0] ConnectTimeoutRst = 32'd15000;
  localparam logic [31:0] DropToleranceRst  = 32'd3000;
  localparam logic [31:0] BackoffBaseRst    = 32'd30000;
  localparam logic [3:0]  RetryLimitRst     = 4'd3;
  localparam logic [31:0] RejoinIntervalRst = 32'd60000;
  localparam logic [31:0] RejoinTimeoutRst  = 32'd15000;

  // Configuration bundle from the register file to the core.
  typedef struct packed {
    logic [31:0] connect_timeout;
    logic [31:0] drop_tolerance;
    logic [31:0] backoff_base;
    logic [3:0]  retry_limit;
    logic [31:0] rejoin_interval;
    logic [31:0] rejoin_timeout;
  } cfg_t;

  // One result item.
  typedef struct packed {
    state_e  link_state;
    logic    ap_mode;
    action_e radio_action;
    logic    announce;
    logic    accepted;
  } res_t;

endpackage

>>> rtl/lcs_cfg.sv
// ----------------------------------------------------------------------------
// lcs_cfg: configuration register file
// Six timing and retry registers, written through a plain write port.
// Writes to an unused index are dropped.
// ----------------------------------------------------------------------------
module lcs_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lcs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lcs_pkg::CfgDataW-1:0] cfg_data_i,
  output lcs_pkg::cfg_t                cfg_o
);

  lcs_pkg::cfg_t cfg_q, cfg_d;

  // Decode the index and update the addressed register.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lcs_pkg::REG_CONNECT_TIMEOUT: cfg_d.connect_timeout = cfg_data_i;
        lcs_pkg::REG_DROP_TOLERANCE:  cfg_d.drop_tolerance  = cfg_data_i;
        lcs_pkg::REG_BACKOFF_BASE:    cfg_d.backoff_base    = cfg_data_i;
        lcs_pkg::REG_RETRY_LIMIT:     cfg_d.retry_limit     = cfg_data_i[3:0];
        lcs_pkg::REG_REJOIN_INTERVAL: cfg_d.rejoin_interval = cfg_data_i;
        lcs_pkg::REG_REJOIN_TIMEOUT:  cfg_d.rejoin_timeout  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.connect_timeout <= lcs_pkg::ConnectTimeoutRst;
      cfg_q.drop_tolerance  <= lcs_pkg::DropToleranceRst;
      cfg_q.backoff_base    <= lcs_pkg::BackoffBaseRst;
      cfg_q.retry_limit     <= lcs_pkg::RetryLimitRst;
      cfg_q.rejoin_interval <= lcs_pkg::RejoinIntervalRst;
      cfg_q.rejoin_timeout  <= lcs_pkg::RejoinTimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/lcs_core.sv
// ----------------------------------------------------------------------------
// lcs_core: link supervision state machine
// Holds the link state and its timers and computes, for one registered
// request, the next state and the result item. A single elapsed-time
// subtractor and comparator is shared by all timers, selected by state.
// ----------------------------------------------------------------------------
module lcs_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [2:0]    cmd_i,
  input  logic [1:0]    link_status_i,
  input  logic [31:0]   now_ms_i,
  input  logic          has_network_name_i,
  input  lcs_pkg::cfg_t cfg_i,
  output lcs_pkg::res_t res_o
);

  // Retry delay: base doubled per retry, saturating at all ones.
  function automatic logic [31:0] backoff_delay(logic [3:0] count, logic [31:0] base);
    logic [46:0] wide;
    wide = {15'd0, base} << count;
    if (wide[46:32] != 15'd0) begin
      return 32'hFFFF_FFFF;
    end
    return wide[31:0];
  endfunction

  lcs_pkg::state_e state_q, state_d;
  logic        mode_ap_q, mode_ap_d;
  logic        cred_q, cred_d;
  logic [31:0] join_start_q, join_start_d;
  logic [3:0]  retries_q, retries_d;
  logic        retry_armed_q, retry_armed_d;
  logic [31:0] retry_wait_q, retry_wait_d;
  logic [31:0] retry_since_q, retry_since_d;
  logic        drop_pending_q, drop_pending_d;
  logic [31:0] drop_since_q, drop_since_d;
  logic        rejoin_active_q, rejoin_active_d;
  logic [31:0] rejoin_mark_q, rejoin_mark_d;

  logic [31:0] mark, thr, elapsed;
  logic        el_ge, el_gt, link_up, radio_err, retries_out;

  lcs_pkg::action_e action;
  logic             announce, accepted;

  assign link_up     = (link_status_i == lcs_pkg::LS_CONNECTED);
  assign radio_err   = (link_status_i == lcs_pkg::LS_FAILED) ||
                       (link_status_i == lcs_pkg::LS_ABSENT);
  assign retries_out = (retries_q >= cfg_i.retry_limit);

  // Timer selection: each timed state watches one mark against one limit.
  always_comb begin
    unique case (state_q)
      lcs_pkg::ST_CONNECTING: begin
        mark = join_start_q;
        thr  = cfg_i.connect_timeout;
      end
      lcs_pkg::ST_CONNECTED: begin
        mark = drop_since_q;
        thr  = cfg_i.drop_tolerance;
      end
      lcs_pkg::ST_FAILED: begin
        mark = retry_since_q;
        thr  = retry_wait_q;
      end
      lcs_pkg::ST_AP: begin
        mark = rejoin_mark_q;
        thr  = rejoin_active_q ? cfg_i.rejoin_timeout : cfg_i.rejoin_interval;
      end
      default: begin
        mark = 32'd0;
        thr  = 32'd0;
      end
    endcase
  end

  // Elapsed time wraps modulo 2^32.
  assign elapsed = now_ms_i - mark;
  assign el_ge   = (elapsed >= thr);
  assign el_gt   = el_ge && (elapsed != thr);

  // Next state and timer updates.
  always_comb begin
    state_d         = state_q;
    mode_ap_d       = mode_ap_q;
    cred_d          = cred_q;
    join_start_d    = join_start_q;
    retries_d       = retries_q;
    retry_armed_d   = retry_armed_q;
    retry_wait_d    = retry_wait_q;
    retry_since_d   = retry_since_q;
    drop_pending_d  = drop_pending_q;
    drop_since_d    = drop_since_q;
    rejoin_active_d = rejoin_active_q;
    rejoin_mark_d   = rejoin_mark_q;

    unique case (cmd_i)
      lcs_pkg::CMD_POLL: begin
        unique case (state_q)
          lcs_pkg::ST_CONNECTING: begin
            if (link_up) begin
              state_d       = lcs_pkg::ST_CONNECTED;
              retries_d     = 4'd0;
              retry_armed_d = 1'b0;
            end else if (radio_err || el_gt) begin
              state_d = lcs_pkg::ST_FAILED;
            end
          end
          lcs_pkg::ST_CONNECTED: begin
            if (!link_up) begin
              if (!drop_pending_q) begin
                drop_pending_d = 1'b1;
                drop_since_d   = now_ms_i;
              end else if (el_ge) begin
                state_d        = lcs_pkg::ST_FAILED;
                drop_pending_d = 1'b0;
              end
            end else begin
              drop_pending_d = 1'b0;
            end
          end
          lcs_pkg::ST_DISC: begin
            if (link_up) begin
              state_d = lcs_pkg::ST_CONNECTED;
            end
          end
          lcs_pkg::ST_FAILED: begin
            priority if (link_up) begin
              state_d       = lcs_pkg::ST_CONNECTED;
              retries_d     = 4'd0;
              retry_armed_d = 1'b0;
            end else if (retries_out) begin
              // Retries used up: fall back to access point mode.
              retries_d       = 4'd0;
              mode_ap_d       = 1'b1;
              rejoin_active_d = 1'b0;
              rejoin_mark_d   = now_ms_i;
              state_d         = lcs_pkg::ST_AP;
            end else if (!retry_armed_q) begin
              retry_wait_d  = backoff_delay(retries_q, cfg_i.backoff_base);
              retry_since_d = now_ms_i;
              retries_d     = retries_q + 4'd1;
              retry_armed_d = 1'b1;
            end else if (el_ge) begin
              retry_armed_d = 1'b0;
              if (cred_q) begin
                if (mode_ap_q) begin
                  mode_ap_d       = 1'b0;
                  retries_d       = 4'd0;
                  rejoin_active_d = 1'b0;
                end
                join_start_d = now_ms_i;
                state_d      = lcs_pkg::ST_CONNECTING;
              end
            end
          end
          lcs_pkg::ST_AP: begin
            if (cred_q) begin
              if (rejoin_active_q) begin
                if (link_up) begin
                  mode_ap_d       = 1'b0;
                  rejoin_active_d = 1'b0;
                  retries_d       = 4'd0;
                  retry_armed_d   = 1'b0;
                  state_d         = lcs_pkg::ST_CONNECTED;
                end else if (radio_err || el_ge) begin
                  rejoin_active_d = 1'b0;
                  rejoin_mark_d   = now_ms_i;
                end
              end else if (el_ge) begin
                rejoin_active_d = 1'b1;
                rejoin_mark_d   = now_ms_i;
              end
            end
          end
          default: ;
        endcase
      end
      lcs_pkg::CMD_CONNECT: begin
        if (has_network_name_i) begin
          if (mode_ap_q) begin
            mode_ap_d       = 1'b0;
            retries_d       = 4'd0;
            retry_armed_d   = 1'b0;
            rejoin_active_d = 1'b0;
          end
          cred_d       = 1'b1;
          join_start_d = now_ms_i;
          state_d      = lcs_pkg::ST_CONNECTING;
        end
      end
      lcs_pkg::CMD_DISCONNECT: begin
        if (!mode_ap_q) begin
          state_d = lcs_pkg::ST_DISC;
        end
      end
      lcs_pkg::CMD_START_AP: begin
        mode_ap_d       = 1'b1;
        rejoin_active_d = 1'b0;
        rejoin_mark_d   = now_ms_i;
        state_d         = lcs_pkg::ST_AP;
      end
      lcs_pkg::CMD_STOP_AP: begin
        if (mode_ap_q) begin
          mode_ap_d       = 1'b0;
          retries_d       = 4'd0;
          retry_armed_d   = 1'b0;
          rejoin_active_d = 1'b0;
          state_d         = lcs_pkg::ST_DISC;
        end
      end
      default: ;
    endcase
  end

  // Result outputs: radio action, announce and acceptance.
  always_comb begin
    action   = lcs_pkg::ACT_NONE;
    announce = 1'b0;
    accepted = 1'b1;

    unique case (cmd_i)
      lcs_pkg::CMD_POLL: begin
        unique case (state_q)
          lcs_pkg::ST_CONNECTING, lcs_pkg::ST_DISC: begin
            announce = link_up;
          end
          lcs_pkg::ST_FAILED: begin
            priority if (link_up) begin
              announce = 1'b1;
            end else if (retries_out) begin
              announce = 1'b1;
              action   = lcs_pkg::ACT_START_AP;
            end else if (!retry_armed_q) begin
              action = lcs_pkg::ACT_NONE;
            end else if (el_ge && cred_q) begin
              action = mode_ap_q ? lcs_pkg::ACT_LEAVE_AP_JOIN : lcs_pkg::ACT_JOIN;
            end
          end
          lcs_pkg::ST_AP: begin
            if (cred_q) begin
              if (rejoin_active_q) begin
                if (link_up) begin
                  announce = 1'b1;
                  action   = lcs_pkg::ACT_LEAVE_AP;
                end else if (radio_err || el_ge) begin
                  action = lcs_pkg::ACT_ABORT_KEEP_AP;
                end
              end else if (el_ge) begin
                action = lcs_pkg::ACT_JOIN;
              end
            end
          end
          default: ;
        endcase
      end
      lcs_pkg::CMD_CONNECT: begin
        if (!has_network_name_i) begin
          accepted = 1'b0;
        end else begin
          action = mode_ap_q ? lcs_pkg::ACT_LEAVE_AP_JOIN : lcs_pkg::ACT_JOIN;
        end
      end
      lcs_pkg::CMD_DISCONNECT: begin
        if (!mode_ap_q) begin
          action = lcs_pkg::ACT_DROP;
        end
      end
      lcs_pkg::CMD_START_AP: begin
        announce = 1'b1;
        action   = lcs_pkg::ACT_START_AP;
      end
      lcs_pkg::CMD_STOP_AP: begin
        if (mode_ap_q) begin
          action = lcs_pkg::ACT_LEAVE_AP;
        end
      end
      default: ;
    endcase
  end

  assign res_o.link_state   = state_d;
  assign res_o.ap_mode      = mode_ap_d;
  assign res_o.radio_action = action;
  assign res_o.announce     = announce;
  assign res_o.accepted     = accepted;

  // State registers advance once per processed request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= lcs_pkg::ST_DISC;
      mode_ap_q       <= 1'b0;
      cred_q          <= 1'b0;
      join_start_q    <= 32'd0;
      retries_q       <= 4'd0;
      retry_armed_q   <= 1'b0;
      retry_wait_q    <= 32'd0;
      retry_since_q   <= 32'd0;
      drop_pending_q  <= 1'b0;
      drop_since_q    <= 32'd0;
      rejoin_active_q <= 1'b0;
      rejoin_mark_q   <= 32'd0;
    end else if (step_i) begin
      state_q         <= state_d;
      mode_ap_q       <= mode_ap_d;
      cred_q          <= cred_d;
      join_start_q    <= join_start_d;
      retries_q       <= retries_d;
      retry_armed_q   <= retry_armed_d;
      retry_wait_q    <= retry_wait_d;
      retry_since_q   <= retry_since_d;
      drop_pending_q  <= drop_pending_d;
      drop_since_q    <= drop_since_d;
      rejoin_active_q <= rejoin_active_d;
      rejoin_mark_q   <= rejoin_mark_d;
    end
  end

endmodule

>>> rtl/link_connection_supervisor.sv
// ----------------------------------------------------------------------------
// link_connection_supervisor: wireless link supervisor
// Steps a five-state link machine per request and returns one result per
// request: link state, mode, radio action, announce and acceptance.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake               Payload
//   in       in_valid_i/in_ready_o   cmd, link_status, now_ms, has_network_name
//   out      out_valid_o/out_ready_i link_state, ap_mode, radio_action,
//                                    announce, accepted
//   cfg      cfg_we_i                cfg_idx_i, cfg_data_i
//
// One request per cycle is sustained while the output does not stall; a result
// is offered once its request has passed the input and the result registers.
// The state machine sits between the two registers and advances once per
// request, with one shared elapsed-time compare on the critical path.
// A stalled output holds its result; the input register keeps taking a new
// request whenever the result register moves or is empty.
// Reset puts the link in the disconnected state, station mode, with default
// timings.
module link_connection_supervisor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   cmd_i,
  input  logic [1:0]                   link_status_i,
  input  logic [31:0]                  now_ms_i,
  input  logic                         has_network_name_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   link_state_o,
  output logic                         ap_mode_o,
  output logic [2:0]                   radio_action_o,
  output logic                         announce_o,
  output logic                         accepted_o,
  input  logic                         cfg_we_i,
  input  logic [lcs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lcs_pkg::CfgDataW-1:0] cfg_data_i
);

  lcs_pkg::cfg_t cfg;
  lcs_pkg::res_t res, res_q;

  logic        in_valid_q, out_valid_q, step;
  logic [2:0]  cmd_q;
  logic [1:0]  status_q;
  logic [31:0] now_q;
  logic        name_q;

  // Pipeline flow: process when the result register is free or draining.
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  lcs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q    <= cmd_i;
      status_q <= link_status_i;
      now_q    <= now_ms_i;
      name_q   <= has_network_name_i;
    end
  end

  lcs_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (step),
    .cmd_i              (cmd_q),
    .link_status_i      (status_q),
    .now_ms_i           (now_q),
    .has_network_name_i (name_q),
    .cfg_i              (cfg),
    .res_o              (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign link_state_o   = res_q.link_state;
  assign ap_mode_o      = res_q.ap_mode;
  assign radio_action_o = res_q.radio_action;
  assign announce_o     = res_q.announce;
  assign accepted_o     = res_q.accepted;

endmodule
